FILE: hw/rtl/gsfr_pkg.sv
// ----------------------------------------------------------------------------
// gsfr_pkg
// Types, constants and the byte-wide CRC-16 update for the guide sensor
// frame receiver.
// ----------------------------------------------------------------------------
package gsfr_pkg;

  // Frame lengths in bytes
  localparam logic [3:0] LEN_8PT  = 4'd8;
  localparam logic [3:0] LEN_16PT = 4'd10;
  localparam logic [3:0] CNT_MAX  = 4'd15;

  // Data byte positions
  localparam logic [3:0] DATA_POS0 = 4'd5;
  localparam logic [3:0] DATA_POS1 = 4'd6;
  localparam logic [3:0] DATA_POS2 = 4'd7;

  // CRC-16/Modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_CRC = 2'd2
  } gsfr_status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } gsfr_in_t;

  typedef struct packed {
    gsfr_status_t frame_status;
    logic [15:0]  point_bits;
  } gsfr_out_t;

  // One byte through the reflected CRC, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/guide_sensor_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// guide_sensor_frame_receiver_unit
// Checks a sensor reply frame byte by byte: length, CRC-16/Modbus, and
// extracts the detection point bits.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | gsfr_in_t  (rx_byte, frame_end)
//   out_    | output    | out_valid / out_ready| gsfr_out_t (frame_status, point_bits)
//   cfg_    | input     | cfg_we (no wait)     | cfg_wdata = sixteen_point_mode
//
// One byte per cycle. The byte-wide CRC update and frame bookkeeping sit
// between the frame state registers and the result register.
// A result is registered in the cycle after its last byte and is held until taken;
// a byte is taken while the result register is empty or being drained.
// Synchronous active-low reset clears the frame state and sets 16-point mode.
// ----------------------------------------------------------------------------
module guide_sensor_frame_receiver_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gsfr_pkg::gsfr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gsfr_pkg::gsfr_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import gsfr_pkg::*;

  logic        mode_r;
  logic [3:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] held_r, held_nxt;
  logic [23:0] data_r, data_nxt;
  logic        out_valid_r, out_valid_nxt;
  gsfr_out_t   out_r, out_nxt;

  logic        accept;
  logic [15:0] crc_upd;
  logic [15:0] held_upd;
  logic [23:0] data_upd;
  logic [3:0]  count_upd;
  logic [3:0]  expect_len;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Per-byte update of frame state
  always_comb begin
    crc_upd   = (count_r >= 4'd2) ? crc_feed(crc_r, held_r[15:8]) : crc_r;
    held_upd  = {held_r[7:0], in_data.rx_byte};
    data_upd  = data_r;
    case (count_r)
      DATA_POS0: data_upd[7:0]   = in_data.rx_byte;
      DATA_POS1: data_upd[15:8]  = in_data.rx_byte;
      DATA_POS2: data_upd[23:16] = in_data.rx_byte;
      default:   data_upd        = data_r;
    endcase
    count_upd  = (count_r == CNT_MAX) ? count_r : count_r + 4'd1;
    expect_len = mode_r ? LEN_16PT : LEN_8PT;
  end

  // Frame-end result and next state
  always_comb begin
    count_nxt     = count_r;
    crc_nxt       = crc_r;
    held_nxt      = held_r;
    data_nxt      = data_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      count_nxt = count_upd;
      crc_nxt   = crc_upd;
      held_nxt  = held_upd;
      data_nxt  = data_upd;
      if (in_data.frame_end) begin
        out_valid_nxt      = 1'b1;
        out_nxt.point_bits = 16'h0000;
        if (count_upd != expect_len) begin
          out_nxt.frame_status = ST_BAD_LEN;
        end else if (held_upd[15:8] != crc_upd[7:0] ||
                     held_upd[7:0] != crc_upd[15:8]) begin
          out_nxt.frame_status = ST_BAD_CRC;
        end else begin
          out_nxt.frame_status = ST_OK;
          if (mode_r) begin
            out_nxt.point_bits = {data_upd[16], data_upd[15:8], data_upd[7:1]};
          end else begin
            out_nxt.point_bits = {8'h00, data_upd[7:0]};
          end
        end
        // back to idle frame state
        count_nxt = 4'd0;
        crc_nxt   = CRC_INIT;
        held_nxt  = 16'h0000;
        data_nxt  = 24'h000000;
      end
    end
  end

  // Control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      count_r     <= 4'd0;
      crc_r       <= CRC_INIT;
      held_r      <= 16'h0000;
      data_r      <= 24'h000000;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      held_r      <= held_nxt;
      data_r      <= data_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.frame_end |=> count_r == 4'd0 && crc_r == CRC_INIT)
    else $error("frame state not cleared after last byte");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.frame_end |=> out_valid_r)
    else $error("no result after last byte");

  a_bad_no_points: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_status != ST_OK |-> out_r.point_bits == 16'h0000)
    else $error("point bits set on failed frame");

  a_8pt_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !mode_r |-> out_r.point_bits[15:8] == 8'h00)
    else $error("upper point bits set in 8-point mode");

endmodule
